// ----- rtl/crr_pkg.sv -----
// Shared constants and the pipeline item type for the cascaded range remapper.
`default_nettype none

package crr_pkg;

  localparam int STAGES      = 7;
  localparam int SLOTS       = 64;
  localparam int VALUE_BITS  = 32;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STAGE_IDX_W = 3;
  localparam int SLOT_IDX_W  = 6;
  localparam int HIT_W       = 7;

  // One item as it travels down the pipeline. Load items use the region
  // fields, translate items use value and hits.
  typedef struct packed {
    logic                   lookup;
    logic [STAGE_IDX_W-1:0] stage_index;
    logic [SLOT_IDX_W-1:0]  slot_index;
    logic                   entry_enable;
    logic [VALUE_BITS-1:0]  base;
    logic [VALUE_BITS:0]    region_end;
    logic [VALUE_BITS-1:0]  offset;
    logic [VALUE_BITS-1:0]  value;
    logic [HIT_W-1:0]       hits;
  } crr_item_t;

endpackage

`default_nettype wire

// ----- rtl/cascaded_range_remap.sv -----
// Top level of the cascaded range remapper: input register and stage chain.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o   | mode, stage/slot index, region,
//           |           |                           | lookup_value
//   out     | output    | out_valid_o / out_ready_i | mapped_value, stage_hits
//
// One item is accepted per cycle unless a stall holds the ready chain; a translate
// item passes one input register, then per stage a register after the compare against
// every slot and one after the priority select and add.
// Load items travel down the same pipeline and give no result.
// Reset clears the pipeline valid bits and every slot's valid bit at once.
// A stall ripples back through the ready chain; each register holds its item.
`default_nettype none

module cascaded_range_remap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [crr_pkg::STAGE_IDX_W-1:0]  stage_index_i,
  input  logic [crr_pkg::SLOT_IDX_W-1:0]   slot_index_i,
  input  logic                             entry_enable_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   region_base_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   region_length_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   region_target_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   lookup_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [crr_pkg::VALUE_BITS-1:0]   mapped_value_o,
  output logic [crr_pkg::HIT_W-1:0]        stage_hits_o
);
  import crr_pkg::*;

  logic [STAGES:0] chain_valid;
  logic [STAGES:0] chain_ready;
  crr_item_t       chain_item [STAGES+1];

  crr_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .stage_index_i  (stage_index_i),
    .slot_index_i   (slot_index_i),
    .entry_enable_i (entry_enable_i),
    .region_base_i  (region_base_i),
    .region_length_i(region_length_i),
    .region_target_i(region_target_i),
    .lookup_value_i (lookup_value_i),
    .out_valid_o    (chain_valid[0]),
    .out_ready_i    (chain_ready[0]),
    .out_item_o     (chain_item[0])
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    crr_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_id_i (STAGE_IDX_W'(g)),
      .in_valid_i (chain_valid[g]),
      .in_ready_o (chain_ready[g]),
      .in_item_i  (chain_item[g]),
      .out_valid_o(chain_valid[g+1]),
      .out_ready_i(chain_ready[g+1]),
      .out_item_o (chain_item[g+1])
    );
  end

  // Load items leave the last stage silently.
  assign chain_ready[STAGES] = out_ready_i || !chain_item[STAGES].lookup;
  assign out_valid_o         = chain_valid[STAGES] && chain_item[STAGES].lookup;
  assign mapped_value_o      = chain_item[STAGES].value;
  assign stage_hits_o        = chain_item[STAGES].hits;

endmodule

`default_nettype wire

// ----- rtl/crr_prep.sv -----
// Input register that precomputes region end and translation offset.
`default_nettype none

module crr_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [crr_pkg::STAGE_IDX_W-1:0]  stage_index_i,
  input  logic [crr_pkg::SLOT_IDX_W-1:0]   slot_index_i,
  input  logic                             entry_enable_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   region_base_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   region_length_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   region_target_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   lookup_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output crr_pkg::crr_item_t               out_item_o
);
  import crr_pkg::*;

  logic      valid_q;
  crr_item_t item_q;
  crr_item_t item_d;
  logic      load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // The end is one bit wider so a region reaching the top cannot wrap.
  // value - base + target equals value + (target - base) modulo 2^VALUE_BITS.
  always_comb begin
    item_d              = '0;
    item_d.lookup       = mode_i;
    item_d.stage_index  = stage_index_i;
    item_d.slot_index   = slot_index_i;
    item_d.entry_enable = entry_enable_i;
    item_d.base         = region_base_i;
    item_d.region_end   = {1'b0, region_base_i} + {1'b0, region_length_i};
    item_d.offset       = region_target_i - region_base_i;
    item_d.value        = lookup_value_i;
    item_d.hits         = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/crr_stage.sv -----
// One remap stage: region table, parallel compare, priority select and add.
`default_nettype none

module crr_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [crr_pkg::STAGE_IDX_W-1:0]  stage_id_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  crr_pkg::crr_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output crr_pkg::crr_item_t               out_item_o
);
  import crr_pkg::*;

  logic [SLOTS-1:0]      slot_valid_q;
  logic [VALUE_BITS-1:0] slot_base_q   [SLOTS];
  logic [VALUE_BITS:0]   slot_end_q    [SLOTS];
  logic [VALUE_BITS-1:0] slot_offset_q [SLOTS];

  logic                  a_valid_q;
  crr_item_t             a_item_q;
  logic [SLOTS-1:0]      a_match_q;
  logic [SLOTS-1:0]      match_d;

  logic                  b_valid_q;
  crr_item_t             b_item_q;
  crr_item_t             b_item_d;

  logic                  a_ready;
  logic                  b_ready;
  logic                  a_load;
  logic                  b_load;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot;
  logic [SLOTS-1:0]      pick;
  logic [VALUE_BITS-1:0] sel_offset;
  logic                  hit;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign a_load     = in_valid_i && a_ready;
  assign b_load     = a_valid_q && b_ready;

  // A load item updates the table as it passes this stage, so items ahead
  // of it have already been compared and items behind it see the new entry.
  assign wr_slot = in_item_i.slot_index[SLOT_W-1:0];
  assign wr_en   = a_load && !in_item_i.lookup && (in_item_i.stage_index == stage_id_i) &&
                   (32'(in_item_i.slot_index) < SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (wr_en) begin
      slot_valid_q[wr_slot] <= in_item_i.entry_enable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_base_q[wr_slot]   <= in_item_i.base;
      slot_end_q[wr_slot]    <= in_item_i.region_end;
      slot_offset_q[wr_slot] <= in_item_i.offset;
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match_d[s] = in_item_i.lookup && slot_valid_q[s] &&
                   (in_item_i.value >= slot_base_q[s]) &&
                   ({1'b0, in_item_i.value} < slot_end_q[s]);
    end
  end

  // Isolate the lowest matching slot, then mux its offset in AND-OR form.
  assign pick = a_match_q & (~a_match_q + SLOTS'(1));
  assign hit  = |a_match_q;

  always_comb begin
    sel_offset = '0;
    for (int s = 0; s < SLOTS; s++) begin
      sel_offset = sel_offset | ({VALUE_BITS{pick[s]}} & slot_offset_q[s]);
    end
  end

  always_comb begin
    b_item_d = a_item_q;
    if (hit) begin
      b_item_d.value = a_item_q.value + sel_offset;
      b_item_d.hits  = a_item_q.hits | (HIT_W'(1) << stage_id_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_item_q  <= in_item_i;
      a_match_q <= match_d;
    end
    if (b_load) begin
      b_item_q <= b_item_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

`default_nettype wire

// ----- rtl/crr_checker.sv -----
// Port-level checker for the cascaded range remapper and its bind statement.
`default_nettype none

module crr_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic [crr_pkg::VALUE_BITS-1:0]   mapped_value_o,
  input  logic [crr_pkg::HIT_W-1:0]        stage_hits_o
);
  import crr_pkg::*;

  localparam int DEPTH = 2 * STAGES + 1;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             lookup_in;
  logic             result_out;

  assign lookup_in  = in_valid_i && in_ready_o && mode_i;
  assign result_out = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (lookup_in && !result_out) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!lookup_in && result_out) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(mapped_value_o) && $stable(stage_hits_o))
    else $error("result changed while stalled");

  // Every result belongs to a translate item taken earlier.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without a pending translate item");

  // No more translate items in flight than the pipeline has registers.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("more items in flight than pipeline registers");

  // With the output side ready, the whole ready chain is open.
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

endmodule

bind cascaded_range_remap crr_checker u_crr_checker (.*);

`default_nettype wire
